### sv/pss_pkg.sv
// pfair slot scheduler package: widths, request/result structs, codes
// controller states, datapath operations and the status/command structs
// no dependencies
package pss_pkg;

  localparam int TASK_DEPTH = 32;
  localparam int TASK_W     = 5;
  localparam int TASK_CW    = 6;
  localparam int PROC_NUM   = 16;
  localparam int PROC_W     = 4;
  localparam int PROC_CW    = 5;
  localparam int PER_W      = 16;
  localparam int TIME_W     = 32;
  localparam int X_W        = TIME_W + 1;
  localparam int PROD_W     = X_W + PER_W;
  localparam int MOD_CW     = $clog2(PROD_W + 1);
  localparam int PRM_W      = 2 * PER_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_PROC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK = 1'd1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [TASK_W-1:0] task_index;
    logic [PER_W-1:0]  period;
    logic [PER_W-1:0]  exec_time;
  } pss_req_t;

  typedef struct packed {
    logic [PROC_W-1:0] processor;
    logic [TASK_W-1:0] task_res;
    logic              idle;
    logic              urgent_overflow;
    logic              last;
  } pss_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CL_CHK,
    S_CL_RD,
    S_CL_MTE,
    S_CL_MCP,
    S_CL_LAG,
    S_CL_MOD,
    S_SO_PASS,
    S_SO_CUR,
    S_SO_STEP,
    S_SO_NXT,
    S_CP_RDA,
    S_CP_RDB,
    S_CP_CONST,
    S_CP_SA,
    S_CP_MODA,
    S_CP_SB,
    S_CP_MODB,
    S_CP_WALK,
    S_SO_WR,
    S_PL_CHK,
    S_PL_RD,
    S_PL_ALC,
    S_EM,
    S_FIN
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_TICK,
    OP_CL_RD,
    OP_CL_LAT,
    OP_CL_MTE,
    OP_CL_MCP,
    OP_CL_LAG,
    OP_CL_CLS,
    OP_SO_INIT,
    OP_SO_RD0,
    OP_SO_CUR,
    OP_SO_END,
    OP_SO_RDN,
    OP_SO_NXT,
    OP_CP_RDA,
    OP_CP_RDB,
    OP_CP_IDX,
    OP_CP_MA,
    OP_CP_SA,
    OP_CP_RA,
    OP_CP_SB,
    OP_CP_RB,
    OP_CP_WALK,
    OP_SO_WR,
    OP_PL_INIT,
    OP_PL_RD,
    OP_PL_LAT,
    OP_PL_ALC,
    OP_EM_INIT,
    OP_EM_NEXT,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } pss_cmd_t;

  typedef struct packed {
    logic i_end;
    logic so_more;
    logic step_more;
    logic cp_const;
    logic mod_busy;
    logic walk_dec;
    logic pl_more;
    logic m_zero;
    logic em_last;
  } pss_sts_t;

endpackage

### sv/pfair_slot_scheduler.sv
// pfair pf slot scheduler top level: controller plus datapath
// depends on pss_pkg, pss_ctrl, pss_dp
//
//   channel  direction  handshake                    payload
//   request  in         req_valid_i / req_stall_o     req_i (pss_req_t)
//   result   out        rsp_valid_o / rsp_stall_i     rsp_o (pss_rsp_t)
//   config   in         cfg_we_i                      cfg_idx_i, cfg_data_i
//
// a load request is written while idle, with no change of state; a tick
// classifies each task (including a wait on the bit-serial remainder unit),
// then bubble-sorts the contenders, each compare walking alpha positions
// (no walk when both alpha strings are the same constant), then places
// contenders on processors and emits one result per processor
// no request is taken while a tick is at work or its results are pending
// reset clears the slot time, allocation counts and task count at once, and sets the processor count to one
// a stalled result holds the walk of processors; nothing is lost
module pfair_slot_scheduler
  import pss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_stall_o,
  input  pss_req_t              req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_stall_i,
  output pss_rsp_t              rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  pss_cmd_t cmd;
  pss_sts_t sts;

  pss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_mode_i  (req_i.mode),
    .req_stall_o (req_stall_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pss_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp_o)
  );

endmodule

### sv/pss_ram.sv
// generic single-port-write, single-port-read ram with registered read
// depends on nothing
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/pss_mod.sv
// bit-serial remainder unit: value mod divisor, one bit per cycle
// depends on pss_pkg
module pss_mod
  import pss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] value_i,
  input  logic [PER_W-1:0]  div_i,
  output logic              busy_o,
  output logic [PER_W-1:0]  rem_o
);

  logic [PROD_W-1:0] val_q, val_d;
  logic [PER_W-1:0]  rem_q, rem_d;
  logic [PER_W-1:0]  div_q, div_d;
  logic [MOD_CW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [PER_W:0]    trial;
  logic [PER_W:0]    trial_sub;

  always_comb begin
    trial     = {rem_q, val_q[PROD_W-1]};
    trial_sub = trial - {1'b0, div_q};
  end

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      div_d  = div_i;
      cnt_d  = MOD_CW'(PROD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[PROD_W-2:0], 1'b0};
      rem_d = (trial >= {1'b0, div_q}) ? trial_sub[PER_W-1:0] : trial[PER_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MOD_CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

### sv/pss_ctrl.sv
// controller state machine for the slot scheduler
// depends on pss_pkg; drives pss_dp through the command struct
module pss_ctrl
  import pss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_mode_i,
  output logic     req_stall_o,
  output logic     rsp_valid_o,
  input  logic     rsp_stall_i,
  input  pss_sts_t sts_i,
  output pss_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i && req_mode_i == MODE_TICK) state_d = S_CL_CHK;
      end
      S_CL_CHK:  state_d = sts_i.i_end ? S_SO_PASS : S_CL_RD;
      S_CL_RD:   state_d = S_CL_MTE;
      S_CL_MTE:  state_d = S_CL_MCP;
      S_CL_MCP:  state_d = S_CL_LAG;
      S_CL_LAG:  state_d = S_CL_MOD;
      S_CL_MOD: begin
        if (!sts_i.mod_busy) state_d = S_CL_CHK;
      end
      S_SO_PASS: state_d = sts_i.so_more ? S_SO_CUR : S_PL_CHK;
      S_SO_CUR:  state_d = S_SO_STEP;
      S_SO_STEP: state_d = sts_i.step_more ? S_SO_NXT : S_SO_PASS;
      S_SO_NXT:  state_d = S_CP_RDA;
      S_CP_RDA:  state_d = S_CP_RDB;
      S_CP_RDB:  state_d = S_CP_CONST;
      S_CP_CONST: state_d = sts_i.cp_const ? S_SO_WR : S_CP_SA;
      S_CP_SA:   state_d = S_CP_MODA;
      S_CP_MODA: begin
        if (!sts_i.mod_busy) state_d = S_CP_SB;
      end
      S_CP_SB:   state_d = S_CP_MODB;
      S_CP_MODB: begin
        if (!sts_i.mod_busy) state_d = S_CP_WALK;
      end
      S_CP_WALK: begin
        if (sts_i.walk_dec) state_d = S_SO_WR;
      end
      S_SO_WR:   state_d = S_SO_STEP;
      S_PL_CHK: begin
        if (sts_i.pl_more) state_d = S_PL_RD;
        else state_d = sts_i.m_zero ? S_FIN : S_EM;
      end
      S_PL_RD:   state_d = S_PL_ALC;
      S_PL_ALC:  state_d = S_PL_CHK;
      S_EM: begin
        if (!rsp_stall_i && sts_i.em_last) state_d = S_FIN;
      end
      S_FIN:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op    = OP_NONE;
    req_stall_o = 1'b1;
    rsp_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_stall_o = 1'b0;
        if (req_valid_i) cmd_o.op = (req_mode_i == MODE_TICK) ? OP_TICK : OP_LOAD;
      end
      S_CL_CHK:  cmd_o.op = sts_i.i_end ? OP_SO_INIT : OP_CL_RD;
      S_CL_RD:   cmd_o.op = OP_CL_LAT;
      S_CL_MTE:  cmd_o.op = OP_CL_MTE;
      S_CL_MCP:  cmd_o.op = OP_CL_MCP;
      S_CL_LAG:  cmd_o.op = OP_CL_LAG;
      S_CL_MOD: begin
        if (!sts_i.mod_busy) cmd_o.op = OP_CL_CLS;
      end
      S_SO_PASS: cmd_o.op = sts_i.so_more ? OP_SO_RD0 : OP_PL_INIT;
      S_SO_CUR:  cmd_o.op = OP_SO_CUR;
      S_SO_STEP: cmd_o.op = sts_i.step_more ? OP_SO_RDN : OP_SO_END;
      S_SO_NXT:  cmd_o.op = OP_SO_NXT;
      S_CP_RDA:  cmd_o.op = OP_CP_RDA;
      S_CP_RDB:  cmd_o.op = OP_CP_RDB;
      S_CP_CONST: cmd_o.op = sts_i.cp_const ? OP_CP_IDX : OP_CP_MA;
      S_CP_SA:   cmd_o.op = OP_CP_SA;
      S_CP_MODA: begin
        if (!sts_i.mod_busy) cmd_o.op = OP_CP_RA;
      end
      S_CP_SB:   cmd_o.op = OP_CP_SB;
      S_CP_MODB: begin
        if (!sts_i.mod_busy) cmd_o.op = OP_CP_RB;
      end
      S_CP_WALK: cmd_o.op = OP_CP_WALK;
      S_SO_WR:   cmd_o.op = OP_SO_WR;
      S_PL_CHK:  cmd_o.op = sts_i.pl_more ? OP_PL_RD : OP_EM_INIT;
      S_PL_RD:   cmd_o.op = OP_PL_LAT;
      S_PL_ALC:  cmd_o.op = OP_PL_ALC;
      S_EM: begin
        rsp_valid_o = 1'b1;
        if (!rsp_stall_i) cmd_o.op = OP_EM_NEXT;
      end
      S_FIN:     cmd_o.op = OP_FIN;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

### sv/pss_dp.sv
// slot scheduler datapath: task tables, lag and alpha arithmetic,
// contender list sort and result buffer; depends on pss_pkg, pss_ram, pss_mod
module pss_dp
  import pss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pss_cmd_t              cmd_i,
  output pss_sts_t              sts_o,
  input  pss_req_t              req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output pss_rsp_t              rsp_o
);

  // configuration
  logic [PROC_CW-1:0] pc_q;
  logic [TASK_CW-1:0] tc_q;
  logic [PROC_CW-1:0] m_eff;
  logic [TASK_CW-1:0] n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PROC_CW'(1);
      tc_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROC: pc_q <= cfg_data_i[PROC_CW-1:0];
        CFG_TASK: tc_q <= cfg_data_i[TASK_CW-1:0];
        default: ;
      endcase
    end
  end

  assign m_eff = (pc_q > PROC_CW'(PROC_NUM)) ? PROC_CW'(PROC_NUM) : pc_q;
  assign n_eff = (tc_q > TASK_CW'(TASK_DEPTH)) ? TASK_CW'(TASK_DEPTH) : tc_q;

  // control registers
  logic [TIME_W-1:0]  t_q;
  logic [TASK_CW-1:0] i_q, nu_q, nc_q, j_q, sp_q;
  logic [PROC_CW-1:0] placed_q;
  logic [PROC_W-1:0]  k_q;
  logic [PER_W-1:0]   n_q;
  logic [PROC_NUM-1:0] given_v_q;
  logic [TASK_DEPTH-1:0] alc_v_q;
  logic                alc_vr_q;

  // payload registers
  logic [TASK_W-1:0] given_q [PROC_NUM];
  logic [PER_W-1:0]  pa_q, ea_q, pb_q, eb_q, ra_q, rb_q;
  logic [TIME_W-1:0] cnt_q;
  logic [PROD_W-1:0] prod_q, p1_q;
  logic              lag_gt_q, lag_lt_q, first_q;
  logic [TASK_W-1:0] cur_q, nxt_q;

  // memories
  logic [TASK_W-1:0] prm_raddr, alc_raddr, alc_waddr, con_raddr, con_waddr;
  logic [PRM_W-1:0]  prm_rdata;
  logic [TIME_W-1:0] alc_rdata, alc_wdata;
  logic [TASK_W-1:0] con_rdata, con_wdata;
  logic              prm_we, alc_we, con_we;

  dp_op_e op;
  assign op = cmd_i.op;

  pss_ram #(.WIDTH(PRM_W), .DEPTH(TASK_DEPTH)) u_prm_ram (
    .clk_i   (clk_i),
    .we_i    (prm_we),
    .waddr_i (req_i.task_index),
    .wdata_i ({req_i.period, req_i.exec_time}),
    .raddr_i (prm_raddr),
    .rdata_o (prm_rdata)
  );

  pss_ram #(.WIDTH(TIME_W), .DEPTH(TASK_DEPTH)) u_alc_ram (
    .clk_i   (clk_i),
    .we_i    (alc_we),
    .waddr_i (alc_waddr),
    .wdata_i (alc_wdata),
    .raddr_i (alc_raddr),
    .rdata_o (alc_rdata)
  );

  pss_ram #(.WIDTH(TASK_W), .DEPTH(TASK_DEPTH)) u_con_ram (
    .clk_i   (clk_i),
    .we_i    (con_we),
    .waddr_i (con_waddr),
    .wdata_i (con_wdata),
    .raddr_i (con_raddr),
    .rdata_o (con_rdata)
  );

  // table read fields
  logic [PER_W-1:0]  rd_per, rd_exe;
  logic [TIME_W-1:0] cnt_rd;
  assign rd_per = (prm_rdata[PRM_W-1:PER_W] == '0) ? PER_W'(1) : prm_rdata[PRM_W-1:PER_W];
  assign rd_exe = prm_rdata[PER_W-1:0];
  assign cnt_rd = alc_vr_q ? alc_rdata : '0;

  // multiplier
  logic [X_W-1:0]    x1;
  logic [X_W-1:0]    mul_a;
  logic [PER_W-1:0]  mul_b;
  logic              mul_en;
  assign x1 = {1'b0, t_q} + X_W'(1);

  always_comb begin
    mul_a  = {1'b0, t_q};
    mul_b  = ea_q;
    mul_en = 1'b1;
    case (op)
      OP_CL_MTE: begin mul_a = {1'b0, t_q}; mul_b = ea_q; end
      OP_CL_MCP: begin mul_a = {1'b0, cnt_q}; mul_b = pa_q; end
      OP_CP_MA:  begin mul_a = x1; mul_b = ea_q; end
      OP_CP_RA:  begin mul_a = x1; mul_b = eb_q; end
      default:   mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
  end

  // remainder unit
  logic              mod_start, mod_busy;
  logic [PROD_W-1:0] mod_val;
  logic [PER_W-1:0]  mod_div, mod_rem;

  always_comb begin
    mod_start = 1'b0;
    mod_val   = prod_q;
    mod_div   = pa_q;
    case (op)
      OP_CL_LAG: begin mod_start = 1'b1; mod_val = p1_q; mod_div = pa_q; end
      OP_CP_SA:  begin mod_start = 1'b1; mod_val = prod_q; mod_div = pa_q; end
      OP_CP_SB:  begin mod_start = 1'b1; mod_val = prod_q; mod_div = pb_q; end
      default: ;
    endcase
  end

  pss_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (mod_val),
    .div_i   (mod_div),
    .busy_o  (mod_busy),
    .rem_o   (mod_rem)
  );

  // alpha of the classified task
  logic [PER_W:0] cl_sum;
  logic           cl_gt, cl_lt, urgent, tnegru;
  assign cl_sum = {1'b0, mod_rem} + {1'b0, ea_q};
  assign cl_gt  = cl_sum > {1'b0, pa_q};
  assign cl_lt  = cl_sum < {1'b0, pa_q};
  assign urgent = lag_gt_q && !cl_lt;
  assign tnegru = lag_lt_q && !cl_gt;

  // alpha walk for the compared pair
  logic [PER_W:0] sa, sb, na, nb, na_s, nb_s;
  logic           fa_gt, fa_lt, fb_gt, fb_lt, w_diff, w_zero, a_first;
  logic           ca, cb;
  assign sa    = {1'b0, ra_q} + {1'b0, ea_q};
  assign sb    = {1'b0, rb_q} + {1'b0, eb_q};
  assign fa_gt = sa > {1'b0, pa_q};
  assign fa_lt = sa < {1'b0, pa_q};
  assign fb_gt = sb > {1'b0, pb_q};
  assign fb_lt = sb < {1'b0, pb_q};
  assign w_diff  = (fa_gt != fb_gt) || (fa_lt != fb_lt);
  assign w_zero  = !fa_gt && !fa_lt;
  assign a_first = (fa_gt && !fb_gt) || (w_zero && fb_lt);
  assign na    = sa;
  assign nb    = sb;
  assign na_s  = na - {1'b0, pa_q};
  assign nb_s  = nb - {1'b0, pb_q};
  assign ca    = (ea_q == '0) || (ea_q > pa_q);
  assign cb    = (eb_q == '0) || (eb_q > pb_q);

  // status
  logic [TASK_CW:0] j_sp;
  assign j_sp = {1'b0, j_q} + {1'b0, sp_q};

  always_comb begin
    sts_o.i_end     = (i_q == n_eff);
    sts_o.so_more   = (sp_q < nc_q);
    sts_o.step_more = (j_sp < {1'b0, nc_q});
    sts_o.cp_const  = ca && cb && ((ea_q > pa_q) == (eb_q > pb_q));
    sts_o.mod_busy  = mod_busy;
    sts_o.walk_dec  = w_diff || w_zero || (n_q == '1);
    sts_o.pl_more   = (j_q < nc_q) && (placed_q < m_eff);
    sts_o.m_zero    = (m_eff == '0);
    sts_o.em_last   = ({1'b0, k_q} + PROC_CW'(1)) == m_eff;
  end

  // memory ports
  always_comb begin
    prm_raddr = i_q[TASK_W-1:0];
    alc_raddr = i_q[TASK_W-1:0];
    con_raddr = j_q[TASK_W-1:0];
    case (op)
      OP_SO_NXT: prm_raddr = cur_q;
      OP_CP_RDA: prm_raddr = nxt_q;
      OP_PL_LAT: alc_raddr = con_rdata;
      OP_SO_RD0: con_raddr = '0;
      OP_SO_RDN: con_raddr = j_q[TASK_W-1:0] + TASK_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    prm_we    = (op == OP_LOAD);
    alc_we    = 1'b0;
    alc_waddr = i_q[TASK_W-1:0];
    alc_wdata = cnt_q + TIME_W'(1);
    con_we    = 1'b0;
    con_waddr = j_q[TASK_W-1:0];
    con_wdata = cur_q;
    case (op)
      OP_CL_CLS: begin
        if (urgent) begin
          alc_we = (placed_q < m_eff);
        end else if (!tnegru) begin
          con_we    = 1'b1;
          con_waddr = nc_q[TASK_W-1:0];
          con_wdata = i_q[TASK_W-1:0];
        end
      end
      OP_SO_END: con_we = 1'b1;
      OP_SO_WR: begin
        con_we    = 1'b1;
        con_wdata = first_q ? cur_q : nxt_q;
      end
      OP_PL_ALC: begin
        alc_we    = 1'b1;
        alc_waddr = cur_q;
        alc_wdata = cnt_rd + TIME_W'(1);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q       <= '0;
      i_q       <= '0;
      nu_q      <= '0;
      nc_q      <= '0;
      j_q       <= '0;
      sp_q      <= '0;
      placed_q  <= '0;
      k_q       <= '0;
      n_q       <= '0;
      given_v_q <= '0;
      alc_v_q   <= '0;
      alc_vr_q  <= 1'b0;
    end else begin
      alc_vr_q <= alc_v_q[alc_raddr];
      if (alc_we) alc_v_q[alc_waddr] <= 1'b1;
      case (op)
        OP_LOAD: alc_v_q[req_i.task_index] <= 1'b0;
        OP_TICK: begin
          i_q       <= '0;
          nu_q      <= '0;
          nc_q      <= '0;
          placed_q  <= '0;
          given_v_q <= '0;
        end
        OP_CL_CLS: begin
          i_q <= i_q + TASK_CW'(1);
          if (urgent) begin
            nu_q <= nu_q + TASK_CW'(1);
            if (placed_q < m_eff) begin
              given_v_q[placed_q[PROC_W-1:0]] <= 1'b1;
              placed_q <= placed_q + PROC_CW'(1);
            end
          end else if (!tnegru) begin
            nc_q <= nc_q + TASK_CW'(1);
          end
        end
        OP_SO_INIT: sp_q <= TASK_CW'(1);
        OP_SO_RD0:  j_q  <= '0;
        OP_SO_END:  sp_q <= sp_q + TASK_CW'(1);
        OP_CP_RB:   n_q  <= '0;
        OP_CP_WALK: n_q  <= n_q + PER_W'(1);
        OP_SO_WR:   j_q  <= j_q + TASK_CW'(1);
        OP_PL_INIT: j_q  <= '0;
        OP_PL_ALC: begin
          given_v_q[placed_q[PROC_W-1:0]] <= 1'b1;
          placed_q <= placed_q + PROC_CW'(1);
          j_q      <= j_q + TASK_CW'(1);
        end
        OP_EM_INIT: k_q <= '0;
        OP_EM_NEXT: k_q <= k_q + PROC_W'(1);
        OP_FIN:     t_q <= t_q + TIME_W'(1);
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (op)
      OP_CL_LAT: begin
        pa_q  <= rd_per;
        ea_q  <= rd_exe;
        cnt_q <= cnt_rd;
      end
      OP_CL_MCP: p1_q <= prod_q;
      OP_CL_LAG: begin
        lag_gt_q <= p1_q > prod_q;
        lag_lt_q <= p1_q < prod_q;
      end
      OP_CL_CLS: begin
        if (urgent && (placed_q < m_eff)) given_q[placed_q[PROC_W-1:0]] <= i_q[TASK_W-1:0];
      end
      OP_SO_CUR: cur_q <= con_rdata;
      OP_SO_NXT: nxt_q <= con_rdata;
      OP_CP_RDA: begin
        pa_q <= rd_per;
        ea_q <= rd_exe;
      end
      OP_CP_RDB: begin
        pb_q <= rd_per;
        eb_q <= rd_exe;
      end
      OP_CP_IDX: first_q <= cur_q < nxt_q;
      OP_CP_RA:  ra_q <= mod_rem;
      OP_CP_RB:  rb_q <= mod_rem;
      OP_CP_WALK: begin
        if (w_diff) begin
          first_q <= a_first;
        end else begin
          first_q <= cur_q < nxt_q;
        end
        if (ea_q <= pa_q) ra_q <= (na >= {1'b0, pa_q}) ? na_s[PER_W-1:0] : na[PER_W-1:0];
        if (eb_q <= pb_q) rb_q <= (nb >= {1'b0, pb_q}) ? nb_s[PER_W-1:0] : nb[PER_W-1:0];
      end
      OP_SO_WR: begin
        if (first_q) cur_q <= nxt_q;
      end
      OP_PL_LAT: cur_q <= con_rdata;
      OP_PL_ALC: given_q[placed_q[PROC_W-1:0]] <= cur_q;
      default: ;
    endcase
  end

  // result
  always_comb begin
    rsp_o.processor       = k_q;
    rsp_o.task_res        = given_v_q[k_q] ? given_q[k_q] : '0;
    rsp_o.idle            = !given_v_q[k_q];
    rsp_o.urgent_overflow = nu_q > {1'b0, m_eff};
    rsp_o.last            = sts_o.em_last;
  end

endmodule
